// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers; expect signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante must imply cons in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// ante must imply cons in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/ppmfd_pkg.sv -----
package ppmfd_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 20;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [1:0] PH_UNSYNCED = 2'd0;
   localparam logic [1:0] PH_ARMED    = 2'd1;
   localparam logic [1:0] PH_ACTIVE   = 2'd2;
   localparam logic [1:0] PH_INACTIVE = 2'd3;

   localparam logic [2:0] CSR_MIN_PULSE_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_MAX_PULSE_WIDTH   = 3'd1;
   localparam logic [2:0] CSR_MIN_CHANNEL_VALUE = 3'd2;
   localparam logic [2:0] CSR_MAX_CHANNEL_VALUE = 3'd3;
   localparam logic [2:0] CSR_MIN_START_GAP     = 3'd4;
   localparam logic [2:0] CSR_MIN_CHANNELS      = 3'd5;
   localparam logic [2:0] CSR_LOCK_FRAMES       = 3'd6;

   localparam logic [15:0] RST_MIN_PULSE_WIDTH   = 16'd200;
   localparam logic [15:0] RST_MAX_PULSE_WIDTH   = 16'd600;
   localparam logic [15:0] RST_MIN_CHANNEL_VALUE = 16'd800;
   localparam logic [15:0] RST_MAX_CHANNEL_VALUE = 16'd2200;
   localparam logic [15:0] RST_MIN_START_GAP     = 16'd2300;
   localparam logic [4:0]  RST_MIN_CHANNELS      = 5'd5;
   localparam logic [3:0]  RST_LOCK_FRAMES       = 4'd4;

   typedef struct packed {
      logic [1:0]  phase;
      logic [4:0]  decoded_channels;
      logic [15:0] frame_length;
      logic        frame_error;
   } status_type;

endpackage

// ----- rtl/ppmfd_queue.sv -----
module ppmfd_queue #(
   parameter int DEPTH = ppmfd_pkg::QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/ppmfd_front.sv -----
module ppmfd_front #(
   parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEFAULT,
   parameter int CNT_W        = $clog2(MAX_CHANNELS + 1),
   parameter int IDX_W        = $clog2(MAX_CHANNELS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [15:0]          req_edge_time,
   output logic                 push,
   output logic [CNT_W-1:0]     push_count,
   output ppmfd_pkg::status_type push_status,
   input  logic                 queue_full,
   input  logic                 publish_done,
   output logic                 publish_pending,
   output logic                 buf_we,
   output logic [IDX_W-1:0]     buf_addr,
   output logic [15:0]          buf_data
);

   localparam int CW = (CNT_W > 5) ? CNT_W : 5;

   logic [15:0] min_pw_ff, min_pw_in, max_pw_ff, max_pw_in;
   logic [15:0] min_cv_ff, min_cv_in, max_cv_ff, max_cv_in;
   logic [15:0] start_gap_ff, start_gap_in;
   logic [4:0]  min_ch_ff, min_ch_in;
   logic [3:0]  lock_ff, lock_in;

   logic [15:0]      last_edge_ff, last_edge_in;
   logic [15:0]      last_mark_ff, last_mark_in;
   logic [15:0]      frame_start_ff, frame_start_in;
   logic [15:0]      frame_len_ff, frame_len_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] accepted_ff, accepted_in;
   logic [CNT_W-1:0] candidate_ff, candidate_in;
   logic [3:0]       holdoff_ff, holdoff_in;
   logic [1:0]       phase_ff, phase_in;
   logic             pend_ff, pend_in;

   logic             accept;
   logic [15:0]      width_w, ivl_w;
   logic             pulse_ok, err;
   logic [CNT_W-1:0] pub_cnt;

   assign req_stall       = pend_ff || queue_full;
   assign accept          = req_valid && !req_stall;
   assign publish_pending = pend_ff;
   assign width_w         = req_edge_time - last_edge_ff;
   assign ivl_w           = req_edge_time - last_mark_ff;
   assign pulse_ok        = (width_w >= min_pw_ff) && (width_w <= max_pw_ff);

   always_comb begin
      min_pw_in      = min_pw_ff;
      max_pw_in      = max_pw_ff;
      min_cv_in      = min_cv_ff;
      max_cv_in      = max_cv_ff;
      start_gap_in   = start_gap_ff;
      min_ch_in      = min_ch_ff;
      lock_in        = lock_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ppmfd_pkg::CSR_MIN_PULSE_WIDTH:   min_pw_in    = csr_write_data;
            ppmfd_pkg::CSR_MAX_PULSE_WIDTH:   max_pw_in    = csr_write_data;
            ppmfd_pkg::CSR_MIN_CHANNEL_VALUE: min_cv_in    = csr_write_data;
            ppmfd_pkg::CSR_MAX_CHANNEL_VALUE: max_cv_in    = csr_write_data;
            ppmfd_pkg::CSR_MIN_START_GAP:     start_gap_in = csr_write_data;
            ppmfd_pkg::CSR_MIN_CHANNELS:      min_ch_in    = csr_write_data[4:0];
            ppmfd_pkg::CSR_LOCK_FRAMES:       lock_in      = csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      last_edge_in   = last_edge_ff;
      last_mark_in   = last_mark_ff;
      frame_start_in = frame_start_ff;
      frame_len_in   = frame_len_ff;
      cursor_in      = cursor_ff;
      accepted_in    = accepted_ff;
      candidate_in   = candidate_ff;
      holdoff_in     = holdoff_ff;
      phase_in       = phase_ff;
      pend_in        = publish_done ? 1'b0 : pend_ff;
      err            = 1'b0;
      pub_cnt        = '0;
      buf_we         = 1'b0;
      buf_addr       = cursor_ff[IDX_W-1:0];
      buf_data       = ivl_w;

      if (accept) begin
         if (width_w >= start_gap_ff) begin
            if (cursor_ff != accepted_ff) begin
               if (candidate_ff != cursor_ff) begin
                  candidate_in = cursor_ff;
                  holdoff_in   = lock_ff;
               end else if (holdoff_ff != 4'd0) begin
                  holdoff_in = holdoff_ff - 4'd1;
               end else begin
                  accepted_in  = candidate_ff;
                  candidate_in = '0;
               end
            end else if (CW'(cursor_ff) >= CW'(min_ch_ff)) begin
               pub_cnt = cursor_ff;
            end
            cursor_in    = '0;
            phase_in     = ppmfd_pkg::PH_ARMED;
            last_edge_in = req_edge_time;
            if (pub_cnt != '0) begin
               pend_in = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               ppmfd_pkg::PH_ARMED: begin
                  if (!pulse_ok) begin
                     err = 1'b1;
                  end else begin
                     last_mark_in   = last_edge_ff;
                     frame_len_in   = last_edge_ff - frame_start_ff;
                     frame_start_in = last_edge_ff;
                     phase_in       = ppmfd_pkg::PH_ACTIVE;
                  end
               end
               ppmfd_pkg::PH_INACTIVE: begin
                  if (!pulse_ok) begin
                     err = 1'b1;
                  end else begin
                     phase_in = ppmfd_pkg::PH_ACTIVE;
                  end
               end
               ppmfd_pkg::PH_ACTIVE: begin
                  last_mark_in = req_edge_time;
                  if (ivl_w < min_cv_ff || ivl_w > max_cv_ff) begin
                     err = 1'b1;
                  end else begin
                     if (cursor_ff < CNT_W'(MAX_CHANNELS)) begin
                        buf_we    = 1'b1;
                        cursor_in = cursor_ff + CNT_W'(1);
                     end
                     phase_in = ppmfd_pkg::PH_INACTIVE;
                  end
               end
               default: ;
            endcase
            if (err) begin
               phase_in    = ppmfd_pkg::PH_UNSYNCED;
               accepted_in = '0;
            end else begin
               last_edge_in = req_edge_time;
            end
         end
      end
   end

   assign push                         = accept;
   assign push_count                   = pub_cnt;
   assign push_status.phase            = phase_in;
   assign push_status.decoded_channels = 5'(accepted_in);
   assign push_status.frame_length     = frame_len_in;
   assign push_status.frame_error      = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pw_ff      <= ppmfd_pkg::RST_MIN_PULSE_WIDTH;
         max_pw_ff      <= ppmfd_pkg::RST_MAX_PULSE_WIDTH;
         min_cv_ff      <= ppmfd_pkg::RST_MIN_CHANNEL_VALUE;
         max_cv_ff      <= ppmfd_pkg::RST_MAX_CHANNEL_VALUE;
         start_gap_ff   <= ppmfd_pkg::RST_MIN_START_GAP;
         min_ch_ff      <= ppmfd_pkg::RST_MIN_CHANNELS;
         lock_ff        <= ppmfd_pkg::RST_LOCK_FRAMES;
         last_edge_ff   <= '0;
         last_mark_ff   <= '0;
         frame_start_ff <= '0;
         frame_len_ff   <= '0;
         cursor_ff      <= '0;
         accepted_ff    <= '0;
         candidate_ff   <= '0;
         holdoff_ff     <= '0;
         phase_ff       <= ppmfd_pkg::PH_UNSYNCED;
         pend_ff        <= 1'b0;
      end else begin
         min_pw_ff      <= min_pw_in;
         max_pw_ff      <= max_pw_in;
         min_cv_ff      <= min_cv_in;
         max_cv_ff      <= max_cv_in;
         start_gap_ff   <= start_gap_in;
         min_ch_ff      <= min_ch_in;
         lock_ff        <= lock_in;
         last_edge_ff   <= last_edge_in;
         last_mark_ff   <= last_mark_in;
         frame_start_ff <= frame_start_in;
         frame_len_ff   <= frame_len_in;
         cursor_ff      <= cursor_in;
         accepted_ff    <= accepted_in;
         candidate_ff   <= candidate_in;
         holdoff_ff     <= holdoff_in;
         phase_ff       <= phase_in;
         pend_ff        <= pend_in;
      end
   end

endmodule

// ----- rtl/ppmfd_back.sv -----
module ppmfd_back #(
   parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEFAULT,
   parameter int CNT_W        = $clog2(MAX_CHANNELS + 1),
   parameter int IDX_W        = $clog2(MAX_CHANNELS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  logic [CNT_W-1:0]      cmd_count,
   input  ppmfd_pkg::status_type cmd_status,
   output logic                  cmd_pop,
   input  logic                  buf_we,
   input  logic [IDX_W-1:0]      buf_addr,
   input  logic [15:0]           buf_data,
   output logic                  publish_done,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_channel_valid,
   output logic [4:0]            rsp_channel_index,
   output logic [15:0]           rsp_channel_value,
   output logic                  rsp_last,
   output logic [1:0]            rsp_decoder_phase,
   output logic [4:0]            rsp_decoded_channels,
   output logic [15:0]           rsp_frame_length,
   output logic                  rsp_frame_error
);

   localparam logic BK_IDLE = 1'b0;
   localparam logic BK_PUB  = 1'b1;

   logic [15:0] interval_mem [MAX_CHANNELS];
   logic [15:0] rd_data_ff;

   logic                  state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   ppmfd_pkg::status_type st_ff, st_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_chv_ff, out_chv_in;
   logic [4:0]            out_idx_ff, out_idx_in;
   logic [15:0]           out_val_ff, out_val_in;
   logic                  out_last_ff, out_last_in;
   ppmfd_pkg::status_type out_st_ff, out_st_in;

   logic out_free, at_last;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign at_last  = (CNT_W'(idx_ff) + CNT_W'(1) == cnt_ff);
   assign busy     = (state_ff == BK_PUB);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      cmd_pop      = 1'b0;
      publish_done = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_chv_in   = out_chv_ff;
      out_idx_in   = out_idx_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      out_st_in    = out_st_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               if (cmd_count == '0) begin
                  out_valid_in = 1'b1;
                  out_chv_in   = 1'b0;
                  out_idx_in   = '0;
                  out_val_in   = '0;
                  out_last_in  = 1'b1;
                  out_st_in    = cmd_status;
               end else begin
                  state_in = BK_PUB;
                  idx_in   = '0;
                  cnt_in   = cmd_count;
                  st_in    = cmd_status;
               end
            end
         end
         BK_PUB: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_chv_in   = 1'b1;
               out_idx_in   = 5'(idx_ff);
               out_val_in   = rd_data_ff;
               out_last_in  = at_last;
               out_st_in    = st_ff;
               if (at_last) begin
                  state_in     = BK_IDLE;
                  publish_done = 1'b1;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      st_ff       <= st_in;
      out_chv_ff  <= out_chv_in;
      out_idx_ff  <= out_idx_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
      out_st_ff   <= out_st_in;
   end

   // read follows the next index so data lines up with idx_ff
   always_ff @(posedge clock) begin
      if (buf_we) begin
         interval_mem[buf_addr] <= buf_data;
      end
      rd_data_ff <= interval_mem[idx_in];
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_channel_valid    = out_chv_ff;
   assign rsp_channel_index    = out_idx_ff;
   assign rsp_channel_value    = out_val_ff;
   assign rsp_last             = out_last_ff;
   assign rsp_decoder_phase    = out_st_ff.phase;
   assign rsp_decoded_channels = out_st_ff.decoded_channels;
   assign rsp_frame_length     = out_st_ff.frame_length;
   assign rsp_frame_error      = out_st_ff.frame_error;

endmodule

// ----- rtl/ppm_frame_decoder_core.sv -----
// channel  ports                          direction  beat
// req      req_valid/req_stall            in         one edge timestamp
// rsp      rsp_valid/rsp_stall            out        one status or channel result
// csr      csr_write_enable/index/data    in         one register write
//
// Front end classifies one edge per cycle while req is not stalled and queues a command (depth 2).
// Back end pops a publish, then drains it at one channel per cycle unless rsp stalls,
// so a publishing edge holds req off until its last channel is loaded for output.
// Other edges give one registered result each, one per cycle unless rsp stalls.
// Reset is synchronous; interval memory is not cleared.
`include "assert_macros.svh"

module ppm_frame_decoder_core #(
   parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_edge_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_channel_valid,
   output logic [4:0]  rsp_channel_index,
   output logic [15:0] rsp_channel_value,
   output logic        rsp_last,
   output logic [1:0]  rsp_decoder_phase,
   output logic [4:0]  rsp_decoded_channels,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_frame_error
);

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int IDX_W = $clog2(MAX_CHANNELS);
   localparam int ST_W  = $bits(ppmfd_pkg::status_type);
   localparam int Q_W   = CNT_W + ST_W;

   logic                  push, q_full, q_empty, q_pop;
   logic [CNT_W-1:0]      push_count;
   ppmfd_pkg::status_type push_status;
   logic [Q_W-1:0]        q_wdata, q_rdata;
   logic                  publish_done, publish_pending, back_busy;
   logic                  buf_we;
   logic [IDX_W-1:0]      buf_addr;
   logic [15:0]           buf_data;

   assign q_wdata = {push_count, push_status};

   ppmfd_front #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .CNT_W(CNT_W),
      .IDX_W(IDX_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_edge_time(req_edge_time),
      .push(push),
      .push_count(push_count),
      .push_status(push_status),
      .queue_full(q_full),
      .publish_done(publish_done),
      .publish_pending(publish_pending),
      .buf_we(buf_we),
      .buf_addr(buf_addr),
      .buf_data(buf_data)
   );

   ppmfd_queue #(
      .DEPTH(ppmfd_pkg::QUEUE_DEPTH),
      .WIDTH(Q_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .wdata(q_wdata),
      .pop(q_pop),
      .rdata(q_rdata),
      .full(q_full),
      .empty(q_empty)
   );

   ppmfd_back #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .CNT_W(CNT_W),
      .IDX_W(IDX_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(!q_empty),
      .cmd_count(q_rdata[Q_W-1:ST_W]),
      .cmd_status(ppmfd_pkg::status_type'(q_rdata[ST_W-1:0])),
      .cmd_pop(q_pop),
      .buf_we(buf_we),
      .buf_addr(buf_addr),
      .buf_data(buf_data),
      .publish_done(publish_done),
      .busy(back_busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_channel_valid(rsp_channel_valid),
      .rsp_channel_index(rsp_channel_index),
      .rsp_channel_value(rsp_channel_value),
      .rsp_last(rsp_last),
      .rsp_decoder_phase(rsp_decoder_phase),
      .rsp_decoded_channels(rsp_decoded_channels),
      .rsp_frame_length(rsp_frame_length),
      .rsp_frame_error(rsp_frame_error)
   );

   `ASSERT_IMPLIES(a_drain_blocks_front, back_busy, publish_pending && req_stall)
   `ASSERT_IMPLIES(a_channel_no_error, rsp_valid && rsp_channel_valid, !rsp_frame_error)
   `ASSERT_NEXT(a_run_unbroken, rsp_valid && rsp_channel_valid && !rsp_last && !rsp_stall,
      rsp_valid && rsp_channel_valid)

endmodule

// ----- dv/ppm_frame_decoder_core_test.sv -----
module ppm_frame_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_DEPTH = ppmfd_pkg::MAX_CHANNELS_DEFAULT;
   localparam logic [2:0] CSR_NO_REGISTER = 3'd7;

   typedef struct packed {
      logic        ch_valid;
      logic [4:0]  ch_index;
      logic [15:0] ch_value;
      logic        last;
      logic [1:0]  phase;
      logic [4:0]  channels;
      logic [15:0] frame_len;
      logic        err;
   } chan_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_edge_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_channel_valid;
   logic [4:0]  rsp_channel_index;
   logic [15:0] rsp_channel_value;
   logic        rsp_last;
   logic [1:0]  rsp_decoder_phase;
   logic [4:0]  rsp_decoded_channels;
   logic [15:0] rsp_frame_length;
   logic        rsp_frame_error;

   // decoder copy: registers
   logic [15:0] reg_min_pw;
   logic [15:0] reg_max_pw;
   logic [15:0] reg_min_ch;
   logic [15:0] reg_max_ch;
   logic [15:0] reg_min_gap;
   logic [4:0]  reg_min_channels;
   logic [3:0]  reg_lock;

   // decoder copy: state
   logic [15:0] m_last_edge;
   logic [15:0] m_last_mark;
   logic [15:0] m_frame_start;
   logic [4:0]  m_cursor;
   logic [1:0]  m_phase;
   logic [4:0]  m_accepted;
   logic [4:0]  m_candidate;
   logic [3:0]  m_holdoff;
   logic [15:0] m_frame_len;
   logic [15:0] m_intervals [BUF_DEPTH];

   chan_result_type pending_results [$];
   int unsigned  mismatches = 0;
   int unsigned  edges_sent = 0;
   logic [15:0]  edge_clock = '0;
   int           send_idle_pct = 20;
   int           recv_idle_pct = 59;
   int           hold_request = 0;
   int           hold_left = 0;

   ppm_frame_decoder_core u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_edge_time        (req_edge_time),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_channel_valid    (rsp_channel_valid),
      .rsp_channel_index    (rsp_channel_index),
      .rsp_channel_value    (rsp_channel_value),
      .rsp_last             (rsp_last),
      .rsp_decoder_phase    (rsp_decoder_phase),
      .rsp_decoded_channels (rsp_decoded_channels),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_frame_error      (rsp_frame_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic pulse_in_range(input logic [15:0] w);
      return (w >= reg_min_pw) && (w <= reg_max_pw);
   endfunction

   function automatic int pick_between(input int lo, input int hi);
      if (lo <= hi) begin
         return int'($urandom_range(hi, lo));
      end
      return int'($urandom_range(65535, 0));
   endfunction

   function void queue_result(input logic v, input logic [4:0] idx, input logic [15:0] val,
                              input logic lst, input logic fail);
      chan_result_type r;
      r.ch_valid  = v;
      r.ch_index  = idx;
      r.ch_value  = val;
      r.last      = lst;
      r.phase     = m_phase;
      r.channels  = m_accepted;
      r.frame_len = m_frame_len;
      r.err       = fail;
      pending_results.push_back(r);
   endfunction

   function automatic string format_result(input chan_result_type r);
      return $sformatf("valid=%0d idx=%0d value=%0d last=%0d phase=%0d chans=%0d len=%0d err=%0d",
                       r.ch_valid, r.ch_index, r.ch_value, r.last, r.phase, r.channels,
                       r.frame_len, r.err);
   endfunction

   // expected beats for one accepted edge timestamp
   task decode_edge(input logic [15:0] now);
      logic [15:0] width;
      logic [15:0] ivl;
      logic [4:0]  publish;
      logic        fail;
      width = now - m_last_edge;
      fail = 1'b0;
      if (width >= reg_min_gap) begin
         publish = '0;
         if (m_cursor != m_accepted) begin
            if (m_candidate != m_cursor) begin
               m_candidate = m_cursor;
               m_holdoff = reg_lock;
            end else if (m_holdoff != '0) begin
               m_holdoff = m_holdoff - 4'd1;
            end else begin
               m_accepted = m_candidate;
               m_candidate = '0;
            end
         end else if (m_cursor >= reg_min_channels) begin
            publish = m_cursor;
         end
         m_cursor = '0;
         m_phase = ppmfd_pkg::PH_ARMED;
         m_last_edge = now;
         if (publish != '0) begin
            for (int i = 0; i < int'(publish); i++) begin
               queue_result(1'b1, 5'(i), m_intervals[i], (i == int'(publish) - 1), 1'b0);
            end
         end else begin
            queue_result(1'b0, '0, '0, 1'b1, 1'b0);
         end
      end else begin
         case (m_phase)
            ppmfd_pkg::PH_ARMED: begin
               if (!pulse_in_range(width)) begin
                  fail = 1'b1;
               end else begin
                  m_last_mark = m_last_edge;
                  m_frame_len = m_last_edge - m_frame_start;
                  m_frame_start = m_last_edge;
                  m_phase = ppmfd_pkg::PH_ACTIVE;
               end
            end
            ppmfd_pkg::PH_INACTIVE: begin
               if (!pulse_in_range(width)) begin
                  fail = 1'b1;
               end else begin
                  m_phase = ppmfd_pkg::PH_ACTIVE;
               end
            end
            ppmfd_pkg::PH_ACTIVE: begin
               ivl = now - m_last_mark;
               m_last_mark = now;
               if (ivl < reg_min_ch || ivl > reg_max_ch) begin
                  fail = 1'b1;
               end else begin
                  // full buffer drops further intervals
                  if (m_cursor < BUF_DEPTH) begin
                     m_intervals[m_cursor] = ivl;
                     m_cursor = m_cursor + 5'd1;
                  end
                  m_phase = ppmfd_pkg::PH_INACTIVE;
               end
            end
            default: begin
            end
         endcase
         if (fail) begin
            m_phase = ppmfd_pkg::PH_UNSYNCED;
            m_accepted = '0;
         end else begin
            m_last_edge = now;
         end
         queue_result(1'b0, '0, '0, 1'b1, fail);
      end
   endtask

   task write_register(input logic [2:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         ppmfd_pkg::CSR_MIN_PULSE_WIDTH:   reg_min_pw = data;
         ppmfd_pkg::CSR_MAX_PULSE_WIDTH:   reg_max_pw = data;
         ppmfd_pkg::CSR_MIN_CHANNEL_VALUE: reg_min_ch = data;
         ppmfd_pkg::CSR_MAX_CHANNEL_VALUE: reg_max_ch = data;
         ppmfd_pkg::CSR_MIN_START_GAP:     reg_min_gap = data;
         ppmfd_pkg::CSR_MIN_CHANNELS:      reg_min_channels = data[4:0];
         ppmfd_pkg::CSR_LOCK_FRAMES:       reg_lock = data[3:0];
         default: begin
         end
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task load_defaults();
      write_register(ppmfd_pkg::CSR_MIN_PULSE_WIDTH, ppmfd_pkg::RST_MIN_PULSE_WIDTH);
      write_register(ppmfd_pkg::CSR_MAX_PULSE_WIDTH, ppmfd_pkg::RST_MAX_PULSE_WIDTH);
      write_register(ppmfd_pkg::CSR_MIN_CHANNEL_VALUE, ppmfd_pkg::RST_MIN_CHANNEL_VALUE);
      write_register(ppmfd_pkg::CSR_MAX_CHANNEL_VALUE, ppmfd_pkg::RST_MAX_CHANNEL_VALUE);
      write_register(ppmfd_pkg::CSR_MIN_START_GAP, ppmfd_pkg::RST_MIN_START_GAP);
      write_register(ppmfd_pkg::CSR_MIN_CHANNELS, 16'(ppmfd_pkg::RST_MIN_CHANNELS));
      write_register(ppmfd_pkg::CSR_LOCK_FRAMES, 16'(ppmfd_pkg::RST_LOCK_FRAMES));
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // one edge beat; returns at the edge where it was taken
   task send_edge(input logic [15:0] t);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_edge_time <= t;
      do @(posedge clock); while (!(req_valid && !req_stall));
      decode_edge(t);
      edges_sent++;
   endtask

   task send_delta(input logic [15:0] d);
      edge_clock = edge_clock + d;
      send_edge(edge_clock);
   endtask

   // start gap, then n separator/mark pairs; noise adds bad pulses and stray edges
   task send_frame(input int n, input int noise_pct);
      int gap;
      int pw;
      int ch;
      logic [15:0] mark;
      gap = int'(reg_min_gap) + int'($urandom_range(300, 0));
      if (gap > 65535) begin
         gap = 65535;
      end
      mark = edge_clock + 16'(gap);
      send_edge(mark);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99, 0) < noise_pct) begin
            pw = int'($urandom_range(3000, 0));
         end else begin
            pw = pick_between(int'(reg_min_pw), int'(reg_max_pw));
         end
         ch = pick_between(int'(reg_min_ch), int'(reg_max_ch));
         if (ch <= pw) begin
            ch = pw + 1;
         end
         send_edge(mark + 16'(pw));
         mark = mark + 16'(ch);
         send_edge(mark);
         if ($urandom_range(99, 0) < noise_pct) begin
            send_edge(16'($urandom));
         end
      end
      edge_clock = mark;
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      chan_result_type seen;
      chan_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.ch_valid  = rsp_channel_valid;
         seen.ch_index  = rsp_channel_index;
         seen.ch_value  = rsp_channel_value;
         seen.last      = rsp_last;
         seen.phase     = rsp_decoder_phase;
         seen.channels  = rsp_decoded_channels;
         seen.frame_len = rsp_frame_length;
         seen.err       = rsp_frame_error;
         if (pending_results.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected beat: %s", format_result(seen));
            end
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (seen.ch_valid !== want.ch_valid || seen.ch_index !== want.ch_index ||
                seen.ch_value !== want.ch_value || seen.last !== want.last ||
                seen.phase !== want.phase || seen.channels !== want.channels ||
                seen.frame_len !== want.frame_len || seen.err !== want.err) begin
               if (mismatches < 10) begin
                  $display("mismatch at %0t\n  exp: %s\n  got: %s", $realtime,
                           format_result(want), format_result(seen));
               end
               mismatches++;
            end
         end
      end
   end

   // bound edges at reset settings: min/max pulse and interval, exact start gap, wrap
   task test_directed_bounds();
      send_delta(16'd0);
      send_delta(16'd100);
      send_delta(16'd65435);
      send_delta(16'd200);
      send_delta(16'd600);
      send_delta(16'd600);
      send_delta(16'd1600);
      send_delta(16'd601);
      send_delta(16'd1699);
      send_delta(16'd199);
      send_delta(16'd2100);
      send_delta(16'd2300);
      send_delta(16'd300);
      send_delta(16'd499);
      send_delta(16'd2300);
      send_delta(16'd300);
      send_delta(16'd1901);
      send_delta(16'd2400);
      wait_idle();
   endtask

   task test_register_extremes();
      // every edge is a start gap; zero channels match a zero minimum
      write_register(ppmfd_pkg::CSR_MIN_START_GAP, 16'd0);
      write_register(ppmfd_pkg::CSR_MIN_CHANNELS, 16'hFFE0);
      write_register(CSR_NO_REGISTER, 16'h1234);
      repeat (3) send_edge(16'($urandom));
      wait_idle();
      // widest bounds, start gap only at full spacing, longest lock
      write_register(ppmfd_pkg::CSR_MIN_START_GAP, 16'hFFFF);
      write_register(ppmfd_pkg::CSR_MIN_CHANNELS, 16'd1);
      write_register(ppmfd_pkg::CSR_LOCK_FRAMES, 16'hFFFF);
      write_register(ppmfd_pkg::CSR_MIN_PULSE_WIDTH, 16'd0);
      write_register(ppmfd_pkg::CSR_MAX_PULSE_WIDTH, 16'hFFFF);
      write_register(ppmfd_pkg::CSR_MIN_CHANNEL_VALUE, 16'd0);
      write_register(ppmfd_pkg::CSR_MAX_CHANNEL_VALUE, 16'hFFFF);
      send_delta(16'hFFFF);
      send_delta(16'd0);
      send_delta(16'hFFFE);
      send_delta(16'd1);
      send_delta(16'hFFFF);
      send_delta(16'd5);
      send_delta(16'd5);
      send_delta(16'hFFFF);
      wait_idle();
      // inverted bounds fail every check
      write_register(ppmfd_pkg::CSR_MIN_START_GAP, ppmfd_pkg::RST_MIN_START_GAP);
      write_register(ppmfd_pkg::CSR_MIN_PULSE_WIDTH, 16'd600);
      write_register(ppmfd_pkg::CSR_MAX_PULSE_WIDTH, 16'd200);
      write_register(ppmfd_pkg::CSR_MIN_CHANNEL_VALUE, 16'd2200);
      write_register(ppmfd_pkg::CSR_MAX_CHANNEL_VALUE, 16'd800);
      send_delta(16'd3000);
      send_delta(16'd400);
      wait_idle();
      write_register(ppmfd_pkg::CSR_MIN_PULSE_WIDTH, ppmfd_pkg::RST_MIN_PULSE_WIDTH);
      write_register(ppmfd_pkg::CSR_MAX_PULSE_WIDTH, ppmfd_pkg::RST_MAX_PULSE_WIDTH);
      send_delta(16'd3000);
      send_delta(16'd300);
      send_delta(16'd1200);
      wait_idle();
   endtask

   task test_count_lock();
      load_defaults();
      write_register(ppmfd_pkg::CSR_LOCK_FRAMES, 16'd0);
      write_register(ppmfd_pkg::CSR_MIN_CHANNELS, 16'd1);
      repeat (3) send_frame(2, 0);
      repeat (2) send_frame(1, 0);
      send_frame(0, 0);
      wait_idle();
      write_register(ppmfd_pkg::CSR_LOCK_FRAMES, 16'd1);
      repeat (4) send_frame(1, 0);
      send_frame(0, 0);
      wait_idle();
   endtask

   // long receiver hold-off while edges keep coming; the input backs up
   task test_back_pressure();
      load_defaults();
      write_register(ppmfd_pkg::CSR_LOCK_FRAMES, 16'd0);
      write_register(ppmfd_pkg::CSR_MIN_CHANNELS, 16'd1);
      hold_request = 300;
      repeat (3) send_frame(2, 0);
      send_frame(0, 0);
      wait_idle();
   endtask

   task test_random_frames();
      int start;
      int n;
      int reps;
      int a;
      int b;
      for (int seg = 0; seg < 3; seg++) begin
         if (seg == 0) begin
            send_idle_pct = 20;
            recv_idle_pct = 59;
         end else if (seg == 1) begin
            send_idle_pct = 59;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         a = int'($urandom_range(300, 100));
         write_register(ppmfd_pkg::CSR_MIN_PULSE_WIDTH, 16'(a));
         write_register(ppmfd_pkg::CSR_MAX_PULSE_WIDTH, 16'(a + int'($urandom_range(400, 0))));
         b = int'($urandom_range(900, 500));
         write_register(ppmfd_pkg::CSR_MIN_CHANNEL_VALUE, 16'(b));
         b = b + int'($urandom_range(1500, 0));
         write_register(ppmfd_pkg::CSR_MAX_CHANNEL_VALUE, 16'(b));
         write_register(ppmfd_pkg::CSR_MIN_START_GAP, 16'(b + int'($urandom_range(500, 1))));
         write_register(ppmfd_pkg::CSR_MIN_CHANNELS, 16'($urandom_range(4, 1)));
         write_register(ppmfd_pkg::CSR_LOCK_FRAMES, 16'($urandom_range(2, 0)));
         start = edges_sent;
         while (edges_sent - start < 6) begin
            n = int'($urandom_range(3, 1));
            reps = int'($urandom_range(2, 1));
            repeat (reps) send_frame(n, 10);
         end
         send_frame(0, 0);
         wait_idle();
      end
   endtask

   initial begin
      reg_min_pw = ppmfd_pkg::RST_MIN_PULSE_WIDTH;
      reg_max_pw = ppmfd_pkg::RST_MAX_PULSE_WIDTH;
      reg_min_ch = ppmfd_pkg::RST_MIN_CHANNEL_VALUE;
      reg_max_ch = ppmfd_pkg::RST_MAX_CHANNEL_VALUE;
      reg_min_gap = ppmfd_pkg::RST_MIN_START_GAP;
      reg_min_channels = ppmfd_pkg::RST_MIN_CHANNELS;
      reg_lock = ppmfd_pkg::RST_LOCK_FRAMES;
      m_last_edge = '0;
      m_last_mark = '0;
      m_frame_start = '0;
      m_cursor = '0;
      m_phase = ppmfd_pkg::PH_UNSYNCED;
      m_accepted = '0;
      m_candidate = '0;
      m_holdoff = '0;
      m_frame_len = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_bounds();
      test_register_extremes();
      test_count_lock();
      test_back_pressure();
      test_random_frames();
      wait_idle();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
